// ===== rtl/lcsd_pkg.sv =====
// Shared types, constants and a helper function of the syndrome decoder.
`default_nettype none

package lcsd_pkg;

  localparam int CMD_W       = 2;
  localparam int ROW_IDX_W   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int ACC_W       = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_ROW   = 2'd0,
    CMD_LOAD_ENTRY = 2'd1,
    CMD_DECODE     = 2'd2,
    CMD_IDLE       = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_COUNT = 2'd2;

  localparam logic [1:0] BASE_THREE = 2'd3;

  // Residue modulo three by folding base-four digits, since four is one mod three.
  function automatic logic [1:0] mod3(input logic [ACC_W-1:0] v);
    logic [3:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    s2 = {1'b0, s1[1:0]} + {1'b0, s1[3:2]};
    s3 = {1'b0, s2[1:0]} + {2'b00, s2[2]};
    return (s3 == 3'd3) ? 2'd0 : s3[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcsd_front.sv =====
// Front end: takes requests, drops those that do nothing, and feeds the queue.
`default_nettype none

module lcsd_front #(
  parameter int MAX_LENGTH = 16,
  parameter int MAX_CHECKS = 4,
  parameter int DIGIT_BITS = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [lcsd_pkg::CMD_W-1:0]            in_command,
  input  wire logic [lcsd_pkg::ROW_IDX_W-1:0]        in_row_index,
  input  wire logic [MAX_CHECKS*DIGIT_BITS-1:0]      in_row_digits,
  input  wire logic [MAX_CHECKS*DIGIT_BITS-1:0]      in_entry_index,
  input  wire logic                                  in_entry_valid,
  input  wire logic [MAX_LENGTH*DIGIT_BITS-1:0]      in_entry_pattern,
  input  wire logic [MAX_LENGTH*DIGIT_BITS-1:0]      in_received_word,
  input  wire logic [lcsd_pkg::FIFO_CNT_W-1:0]       fifo_level,
  input  wire logic                                  clearing,
  output logic                                       push_valid,
  output logic [lcsd_pkg::CMD_W + $clog2(MAX_LENGTH) + 2*MAX_CHECKS*DIGIT_BITS + 1
                + MAX_LENGTH*DIGIT_BITS - 1:0]       push_data
);
  import lcsd_pkg::*;

  localparam int SYN_W  = MAX_CHECKS * DIGIT_BITS;
  localparam int WORD_W = MAX_LENGTH * DIGIT_BITS;
  localparam int RIDX_W = $clog2(MAX_LENGTH);

  cmd_t              cmd;
  logic              keep;
  logic              accept;
  logic              fr_valid_r;
  cmd_t              fr_cmd_r;
  logic [RIDX_W-1:0] fr_ridx_r;
  logic [SYN_W-1:0]  fr_row_r;
  logic [SYN_W-1:0]  fr_eidx_r;
  logic              fr_evalid_r;
  logic [WORD_W-1:0] fr_data_r;

  // The held request needs a queue slot next cycle, so it counts against the room.
  assign busy = clearing ||
                (({1'b0, fifo_level} + (FIFO_CNT_W+1)'(fr_valid_r)) >= (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_command);

  always_comb begin
    case (cmd)
      CMD_LOAD_ROW:   keep = ({1'b0, in_row_index} < (ROW_IDX_W+1)'(MAX_LENGTH));
      CMD_LOAD_ENTRY: keep = 1'b1;
      CMD_DECODE:     keep = 1'b1;
      default:        keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r    <= cmd;
      fr_ridx_r   <= in_row_index[RIDX_W-1:0];
      fr_row_r    <= in_row_digits;
      fr_eidx_r   <= in_entry_index;
      fr_evalid_r <= in_entry_valid;
      // Loads carry the pattern and decodes the word in the same slot.
      fr_data_r   <= (cmd == CMD_DECODE) ? in_received_word : in_entry_pattern;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_data  = {fr_cmd_r, fr_ridx_r, fr_row_r, fr_eidx_r, fr_evalid_r, fr_data_r};

endmodule

`default_nettype wire

// ===== rtl/lcsd_fifo.sv =====
// Short request queue between the front end and the decode pipeline.
`default_nettype none

module lcsd_fifo #(
  parameter int DATA_W = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire logic [DATA_W-1:0]                 push_data,
  input  wire logic                              pop,
  output logic                                   head_valid,
  output logic [DATA_W-1:0]                      head_data,
  output logic [lcsd_pkg::FIFO_CNT_W-1:0]        level
);
  import lcsd_pkg::*;

  logic [DATA_W-1:0]     slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push && (cnt_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_r + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcsd_back.sv =====
// Back end: check matrix, syndrome pipeline, coset-leader table and result register.
`default_nettype none

module lcsd_back #(
  parameter int MAX_LENGTH = 16,
  parameter int MAX_CHECKS = 4,
  parameter int DIGIT_BITS = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  head_valid,
  input  wire logic [lcsd_pkg::CMD_W + $clog2(MAX_LENGTH) + 2*MAX_CHECKS*DIGIT_BITS + 1
                     + MAX_LENGTH*DIGIT_BITS - 1:0]  head_data,
  output logic                                       pop,
  input  wire logic [MAX_LENGTH-1:0]                 digit_en,
  input  wire logic [MAX_CHECKS-1:0]                 check_en,
  input  wire logic                                  base3,
  output logic                                       clearing,
  output logic                                       out_strobe,
  output logic [MAX_CHECKS*DIGIT_BITS-1:0]           out_syndrome,
  output logic                                       out_error_found,
  output logic [MAX_LENGTH*DIGIT_BITS-1:0]           out_error_pattern
);
  import lcsd_pkg::*;

  localparam int SYN_W  = MAX_CHECKS * DIGIT_BITS;
  localparam int WORD_W = MAX_LENGTH * DIGIT_BITS;
  localparam int RIDX_W = $clog2(MAX_LENGTH);
  localparam int LEN_P2 = 1 << $clog2(MAX_LENGTH);
  localparam int Q_W    = CMD_W + RIDX_W + 2*SYN_W + 1 + WORD_W;
  localparam int TBL_DEPTH = 1 << SYN_W;

  cmd_t              hd_cmd;
  logic [RIDX_W-1:0] hd_ridx;
  logic [SYN_W-1:0]  hd_row;
  logic [SYN_W-1:0]  hd_eidx;
  logic              hd_evalid;
  logic [WORD_W-1:0] hd_data;

  logic [SYN_W-1:0]  hmat_r [MAX_LENGTH];
  logic [ACC_W-1:0]  tree [MAX_CHECKS][LEN_P2];

  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [ACC_W-1:0]  s1_acc_r [MAX_CHECKS];
  logic [SYN_W-1:0]  s1_eidx_r;
  logic              s1_evalid_r;
  logic [WORD_W-1:0] s1_data_r;

  logic [1:0]        rem [MAX_CHECKS];
  logic [SYN_W-1:0]  syn;

  logic [WORD_W:0]   tbl [TBL_DEPTH];
  logic [WORD_W:0]   rd_r;
  logic              clr_active_r;
  logic [SYN_W-1:0]  clr_addr_r;

  logic              s2_dec_r;
  logic [SYN_W-1:0]  s2_syn_r;

  logic              out_strobe_r;
  logic [SYN_W-1:0]  out_syndrome_r;
  logic              out_found_r;
  logic [WORD_W-1:0] out_pattern_r;

  assign hd_cmd    = cmd_t'(head_data[Q_W-1 -: CMD_W]);
  assign hd_ridx   = head_data[WORD_W+1+2*SYN_W +: RIDX_W];
  assign hd_row    = head_data[WORD_W+1+SYN_W +: SYN_W];
  assign hd_eidx   = head_data[WORD_W+1 +: SYN_W];
  assign hd_evalid = head_data[WORD_W];
  assign hd_data   = head_data[WORD_W-1:0];

  assign pop      = head_valid && !clr_active_r;
  assign clearing = clr_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_LENGTH; j++) begin
        hmat_r[j] <= '0;
      end
    end else if (pop && (hd_cmd == CMD_LOAD_ROW)) begin
      hmat_r[hd_ridx] <= hd_row;
    end
  end

  // Per check digit: products of word and matrix digits, summed by a balanced tree.
  always_comb begin
    for (int i = 0; i < MAX_CHECKS; i++) begin
      for (int j = 0; j < LEN_P2; j++) begin
        tree[i][j] = '0;
      end
      for (int j = 0; j < MAX_LENGTH; j++) begin
        if (digit_en[j]) begin
          tree[i][j] = ACC_W'(hd_data[j*DIGIT_BITS +: DIGIT_BITS]) *
                       ACC_W'(hmat_r[j][i*DIGIT_BITS +: DIGIT_BITS]);
        end
      end
      for (int s = 1; s < LEN_P2; s = s * 2) begin
        for (int k = 0; k + s < LEN_P2; k = k + 2*s) begin
          tree[i][k] = tree[i][k] + tree[i][k+s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_cmd_r   <= CMD_IDLE;
    end else begin
      s1_valid_r <= pop;
      s1_cmd_r   <= hd_cmd;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CHECKS; i++) begin
      s1_acc_r[i] <= tree[i][0];
    end
    s1_eidx_r   <= hd_eidx;
    s1_evalid_r <= hd_evalid;
    s1_data_r   <= hd_data;
  end

  // Each residue fills its own digit of the syndrome.
  always_comb begin
    syn = '0;
    for (int i = 0; i < MAX_CHECKS; i++) begin
      if (!check_en[i]) begin
        rem[i] = 2'd0;
      end else if (base3) begin
        rem[i] = mod3(s1_acc_r[i]);
      end else begin
        rem[i] = {1'b0, s1_acc_r[i][0]};
      end
      syn[i*DIGIT_BITS +: DIGIT_BITS] = rem[i][DIGIT_BITS-1:0];
    end
  end

  // Loads and decodes reach the table in request order through the same stage.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      tbl[clr_addr_r] <= '0;
    end else if (s1_valid_r && (s1_cmd_r == CMD_LOAD_ENTRY)) begin
      tbl[s1_eidx_r] <= {s1_evalid_r, s1_data_r};
    end else begin
      rd_r <= tbl[syn];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s2_dec_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + SYN_W'(1);
        if (clr_addr_r == '1) begin
          clr_active_r <= 1'b0;
        end
      end
      s2_dec_r     <= s1_valid_r && (s1_cmd_r == CMD_DECODE);
      out_strobe_r <= s2_dec_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_syn_r       <= syn;
    out_syndrome_r <= s2_syn_r;
    out_found_r    <= rd_r[WORD_W];
    out_pattern_r  <= rd_r[WORD_W] ? rd_r[WORD_W-1:0] : '0;
  end

  assign out_strobe        = out_strobe_r;
  assign out_syndrome      = out_syndrome_r;
  assign out_error_found   = out_found_r;
  assign out_error_pattern = out_pattern_r;

endmodule

`default_nettype wire

// ===== rtl/linear_code_syndrome_decoder_unit.sv =====
// Top level of the syndrome decoder: configuration registers and the front, queue and back.
`default_nettype none

// Syndrome decoder for a linear block code over GF(2) or GF(3).
// A request is taken at a clock edge where start is high and busy is low. Command
// load-row writes one row of the transposed check matrix, load-entry writes one
// coset-leader table entry, decode computes the syndrome of in_received_word and
// looks it up. Idle requests and rows beyond the matrix are dropped.
// A decode result appears on the out_ ports with out_strobe high for one cycle,
// after the front register, the queue and the back pipeline. Loads produce no
// result. One request per cycle is sustained once the table clearing is over: the
// front register, a four-entry queue and a three-stage back pipeline (syndrome
// sum, table read, result register) all advance every cycle. The result side
// cannot stall and the back end takes a request from the queue every cycle, so
// the queue never holds more than one. After reset the coset-leader table is
// cleared one entry per cycle, all 2**(MAX_CHECKS*DIGIT_BITS) entries (256 by
// default); busy stays high meanwhile and at no other time.
// Configuration is written on cfg_valid with cfg_ready, and should only change
// while no decode is in flight. Reset restores base two, length 16 and four checks.
module linear_code_syndrome_decoder_unit #(
  parameter int MAX_LENGTH = 16,
  parameter int MAX_CHECKS = 4,
  parameter int DIGIT_BITS = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [lcsd_pkg::CMD_W-1:0]            in_command,
  input  wire logic [lcsd_pkg::ROW_IDX_W-1:0]        in_row_index,
  input  wire logic [MAX_CHECKS*DIGIT_BITS-1:0]      in_row_digits,
  input  wire logic [MAX_CHECKS*DIGIT_BITS-1:0]      in_entry_index,
  input  wire logic                                  in_entry_valid,
  input  wire logic [MAX_LENGTH*DIGIT_BITS-1:0]      in_entry_pattern,
  input  wire logic [MAX_LENGTH*DIGIT_BITS-1:0]      in_received_word,
  output logic                                       out_strobe,
  output logic [MAX_CHECKS*DIGIT_BITS-1:0]           out_syndrome,
  output logic                                       out_error_found,
  output logic [MAX_LENGTH*DIGIT_BITS-1:0]           out_error_pattern,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [lcsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lcsd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lcsd_pkg::*;

  localparam int SYN_W  = MAX_CHECKS * DIGIT_BITS;
  localparam int WORD_W = MAX_LENGTH * DIGIT_BITS;
  localparam int RIDX_W = $clog2(MAX_LENGTH);
  localparam int Q_W    = CMD_W + RIDX_W + 2*SYN_W + 1 + WORD_W;

  logic [1:0]            symbol_base_r;
  logic [4:0]            code_length_r;
  logic [2:0]            check_count_r;
  logic [MAX_LENGTH-1:0] digit_en;
  logic [MAX_CHECKS-1:0] check_en;
  logic                  base3;

  logic                  push_valid;
  logic [Q_W-1:0]        push_data;
  logic                  pop;
  logic                  head_valid;
  logic [Q_W-1:0]        head_data;
  logic [FIFO_CNT_W-1:0] fifo_level;
  logic                  clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_base_r <= 2'd2;
      code_length_r <= 5'd16;
      check_count_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYMBOL_BASE: symbol_base_r <= cfg_data[1:0];
        REG_CODE_LENGTH: code_length_r <= cfg_data[4:0];
        REG_CHECK_COUNT: check_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Enables per digit position saturate the counts to the built sizes for free.
  always_comb begin
    for (int j = 0; j < MAX_LENGTH; j++) begin
      digit_en[j] = (5'(j) < code_length_r);
    end
    for (int i = 0; i < MAX_CHECKS; i++) begin
      check_en[i] = (3'(i) < check_count_r);
    end
  end

  // Base values below two behave as two, so only three selects the other residue.
  assign base3 = (symbol_base_r == BASE_THREE);

  lcsd_front #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_CHECKS (MAX_CHECKS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_row_index     (in_row_index),
    .in_row_digits    (in_row_digits),
    .in_entry_index   (in_entry_index),
    .in_entry_valid   (in_entry_valid),
    .in_entry_pattern (in_entry_pattern),
    .in_received_word (in_received_word),
    .fifo_level       (fifo_level),
    .clearing         (clearing),
    .push_valid       (push_valid),
    .push_data        (push_data)
  );

  lcsd_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .level      (fifo_level)
  );

  lcsd_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_CHECKS (MAX_CHECKS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_data         (head_data),
    .pop               (pop),
    .digit_en          (digit_en),
    .check_en          (check_en),
    .base3             (base3),
    .clearing          (clearing),
    .out_strobe        (out_strobe),
    .out_syndrome      (out_syndrome),
    .out_error_found   (out_error_found),
    .out_error_pattern (out_error_pattern)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the syndrome decoder: predicts each decode and checks every result.
module testbench;
  import lcsd_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 11;
  localparam int PHASE_ITEMS   = 93;
  localparam int LEADER_KEEP   = 32;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd3;

  typedef struct packed {
    logic [7:0]  syndrome;
    logic        found;
    logic [31:0] pattern;
  } decode_t;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  row;
    logic [7:0]  digits;
    logic [7:0]  entry;
    logic        entry_valid;
    logic [31:0] pattern;
    logic [31:0] word;
  } request_t;

  class syndrome_scoreboard;
    logic [1:0]  base_q;
    logic [4:0]  length_n;
    logic [2:0]  checks_m;
    logic [7:0]  check_rows [16];
    bit          leader_valid [256];
    logic [31:0] leader_pattern [256];
    decode_t     pending [$];
    int          errors;

    function new();
      base_q   = 2'd2;
      length_n = 5'd16;
      checks_m = 3'd4;
      foreach (check_rows[j]) check_rows[j] = '0;
      foreach (leader_valid[e]) begin
        leader_valid[e]   = 1'b0;
        leader_pattern[e] = '0;
      end
      errors = 0;
    endfunction

    // Bases below two behave as base two.
    function int modulus();
      return (base_q < 2'd2) ? 2 : int'(base_q);
    endfunction

    function logic [7:0] syndrome_of(logic [31:0] word);
      int n, m, acc, i, j;
      logic [7:0] syn;
      n = (length_n > 5'd16) ? 16 : int'(length_n);
      m = (checks_m > 3'd4) ? 4 : int'(checks_m);
      syn = '0;
      for (i = 0; i < m; i++) begin
        acc = 0;
        for (j = 0; j < n; j++)
          acc += int'(word[2*j +: 2]) * int'(check_rows[j][2*i +: 2]);
        syn[2*i +: 2] = 2'(acc % modulus());
      end
      return syn;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SYMBOL_BASE: base_q   = data[1:0];
        REG_CODE_LENGTH: length_n = data;
        REG_CHECK_COUNT: checks_m = data[2:0];
        default: ;
      endcase
    endfunction

    function void note_request(request_t r);
      decode_t d;
      case (r.command)
        CMD_LOAD_ROW: check_rows[r.row] = r.digits;
        CMD_LOAD_ENTRY: begin
          leader_valid[r.entry]   = r.entry_valid;
          leader_pattern[r.entry] = r.pattern;
        end
        CMD_DECODE: begin
          d.syndrome = syndrome_of(r.word);
          d.found    = leader_valid[d.syndrome];
          d.pattern  = d.found ? leader_pattern[d.syndrome] : '0;
          pending.insert(pending.size(), d);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_result(decode_t got);
      decode_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with no decode outstanding, syndrome %h", got.syndrome));
        return;
      end
      want = pending.pop_front();
      if (got.syndrome !== want.syndrome)
        report($sformatf("syndrome %h, expected %h", got.syndrome, want.syndrome));
      if (got.found !== want.found)
        report($sformatf("error_found %b, expected %b (syndrome %h)",
                         got.found, want.found, want.syndrome));
      if (got.pattern !== want.pattern)
        report($sformatf("error_pattern %h, expected %h (syndrome %h)",
                         got.pattern, want.pattern, want.syndrome));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      in_command;
  logic [ROW_IDX_W-1:0]  in_row_index;
  logic [7:0]            in_row_digits;
  logic [7:0]            in_entry_index;
  logic                  in_entry_valid;
  logic [31:0]           in_entry_pattern;
  logic [31:0]           in_received_word;
  logic                  out_strobe;
  logic [7:0]            out_syndrome;
  logic                  out_error_found;
  logic [31:0]           out_error_pattern;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  syndrome_scoreboard sb = new();
  logic [31:0] leaders [$];
  int items_sent = 0;
  int idle_cycles = 0;
  int bases   [PHASES] = '{2, 3, 0, 1, 3, 2, 3, 2, 0, 0, 0};
  int lengths [PHASES] = '{16, 16, 0, 31, 1, 17, 8, 5, 0, 0, 0};
  int checks  [PHASES] = '{4, 4, 4, 7, 1, 0, 5, 2, 0, 0, 0};

  linear_code_syndrome_decoder_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_row_index      (in_row_index),
    .in_row_digits     (in_row_digits),
    .in_entry_index    (in_entry_index),
    .in_entry_valid    (in_entry_valid),
    .in_entry_pattern  (in_entry_pattern),
    .in_received_word  (in_received_word),
    .out_strobe        (out_strobe),
    .out_syndrome      (out_syndrome),
    .out_error_found   (out_error_found),
    .out_error_pattern (out_error_pattern),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_syndrome, out_error_found, out_error_pattern});
  end

  // Any handshake counts as progress; the run ends if none is seen for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fields that the command does not use still carry random values.
  function automatic request_t random_request(cmd_t cmd);
    request_t r;
    r.command     = cmd;
    r.row         = 4'($urandom);
    r.digits      = 8'($urandom);
    r.entry       = 8'($urandom);
    r.entry_valid = 1'($urandom);
    r.pattern     = $urandom;
    r.word        = $urandom;
    return r;
  endfunction

  function automatic logic [7:0] random_row();
    logic [7:0] d;
    int i;
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    for (i = 0; i < 4; i++) d[2*i +: 2] = 2'($urandom_range(0, sb.modulus() - 1));
    return d;
  endfunction

  // A likely coset leader: one or two non-zero digits, now and then with noise added.
  function automatic logic [31:0] low_weight_word();
    logic [31:0] w;
    int k;
    w = '0;
    for (k = $urandom_range(1, 2); k > 0; k--)
      w[2*$urandom_range(0, 15) +: 2] = 2'($urandom_range(1, 3));
    if ($urandom_range(0, 7) == 0) w = w | $urandom;
    return w;
  endfunction

  task automatic send(request_t r, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_command       = r.command;
    in_row_index     = r.row;
    in_row_digits    = r.digits;
    in_entry_index   = r.entry;
    in_entry_valid   = r.entry_valid;
    in_entry_pattern = r.pattern;
    in_received_word = r.word;
    start            = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    if (r.command != CMD_IDLE) items_sent++;
  endtask

  task automatic send_row(logic [3:0] row, logic [7:0] digits, int gap);
    request_t r;
    r = random_request(CMD_LOAD_ROW);
    r.row    = row;
    r.digits = digits;
    send(r, gap);
  endtask

  task automatic send_entry(logic [7:0] idx, logic valid, logic [31:0] pattern, int gap);
    request_t r;
    r = random_request(CMD_LOAD_ENTRY);
    r.entry       = idx;
    r.entry_valid = valid;
    r.pattern     = pattern;
    send(r, gap);
  endtask

  task automatic send_decode(logic [31:0] word, int gap);
    request_t r;
    r = random_request(CMD_DECODE);
    r.word = word;
    send(r, gap);
  endtask

  // The table entry goes at the syndrome that the leader has under the present matrix.
  task automatic send_leader(int gap);
    logic [31:0] w;
    w = low_weight_word();
    leaders.insert(leaders.size(), w);
    if (leaders.size() > LEADER_KEEP) void'(leaders.pop_front());
    send_entry(sb.syndrome_of(w), $urandom_range(0, 4) != 0, w, gap);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  task automatic directed_requests();
    // Zero matrix and a cleared table: syndrome zero and nothing found.
    send_decode(32'h0000_0000, 0);
    send_decode(32'hFFFF_FFFF, 0);
    send_row(4'd0, 8'hFF, 0);
    send_row(4'd15, 8'hFF, 0);
    send_row(4'd7, 8'h1B, 1);
    send_row(4'd3, 8'h01, 0);
    send_entry(8'h00, 1'b1, 32'hFFFF_FFFF, 0);
    send_entry(8'hFF, 1'b1, 32'hFFFF_FFFF, 0);
    send_entry(8'h55, 1'b1, 32'h0000_0001, 2);
    send_entry(8'hAA, 1'b0, 32'hDEAD_BEEF, 0);
    send(random_request(CMD_IDLE), 0);
    drain();
    send_decode(32'h0000_0000, 0);
    send_decode(32'hFFFF_FFFF, 0);
    // A digit of three is above base two and still counts in the sum.
    send_decode(32'h0000_0003, 0);
    send_decode(32'hC000_0000, 0);
    send_decode(32'h0000_C000, 1);
    send_decode(32'h0000_00C0, 0);
    send_decode(32'h4000_0001, 0);
    send_decode(32'h5555_5555, 3);
    send_decode(32'hAAAA_AAAA, 0);
    send_entry(8'hAA, 1'b1, 32'h1234_5678, 0);
    send_decode(32'hAAAA_AAAA, 0);
    drain();
  endtask

  task automatic run_phase(int target, bit burst);
    int done_at, r, j;
    logic [31:0] w;
    done_at = items_sent + target;
    for (j = 0; j < 16; j++) send_row(4'(j), random_row(), pick_gap(burst));
    repeat (24) send_leader(pick_gap(burst));
    while (items_sent < done_at) begin
      r = $urandom_range(0, 99);
      // Now and then the sender holds off until every decode has returned.
      if ($urandom_range(0, 99) == 0) drain();
      if (r < 62) begin
        j = $urandom_range(0, 99);
        if (leaders.size() > 0 && j < 50) w = leaders[$urandom_range(0, leaders.size() - 1)];
        else if (j < 55) w = '0;
        else if (j < 60) w = '1;
        else w = $urandom;
        send_decode(w, pick_gap(burst));
      end else if (r < 78) begin
        send_leader(pick_gap(burst));
      end else if (r < 84) begin
        send(random_request(CMD_LOAD_ENTRY), pick_gap(burst));
      end else if (r < 92) begin
        send_row(4'($urandom), random_row(), pick_gap(burst));
      end else begin
        send(random_request(CMD_IDLE), pick_gap(burst));
      end
    end
    drain();
  endtask

  initial begin
    int p;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_IDLE;
    in_row_index     = '0;
    in_row_digits    = '0;
    in_entry_index   = '0;
    in_entry_valid   = 1'b0;
    in_entry_pattern = '0;
    in_received_word = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_SYMBOL_BASE;
    cfg_data         = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Requests go in at once, so they wait out the table clearing pass.
    directed_requests();

    for (p = 0; p < PHASES; p++) begin
      if (p >= 8) begin
        bases[p]   = $urandom_range(0, 3);
        lengths[p] = $urandom_range(0, 31);
        checks[p]  = $urandom_range(0, 7);
      end
      // Bits above the register width are written too and must be dropped.
      write_cfg(REG_SYMBOL_BASE, {3'($urandom), 2'(bases[p])});
      write_cfg(REG_CODE_LENGTH, 5'(lengths[p]));
      write_cfg(REG_CHECK_COUNT, {2'($urandom), 3'(checks[p])});
      if (p == 0) write_cfg(REG_RESERVED, 5'($urandom));
      @(negedge clk);
      cfg_valid = 1'b0;
      run_phase(PHASE_ITEMS, (p % 3) == 1);
    end

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lcsd_pkg.sv
rtl/lcsd_front.sv
rtl/lcsd_fifo.sv
rtl/lcsd_back.sv
rtl/linear_code_syndrome_decoder_unit.sv
dv/testbench.sv
